// ===== sv/peer_slot_table_with_id_allocator_macros.svh =====
// Assertion macros for the peer slot table.
// Depends on nothing; included by the top level, the module that carries assertions.
`ifndef PEER_SLOT_TABLE_WITH_ID_ALLOCATOR_MACROS_SVH
`define PEER_SLOT_TABLE_WITH_ID_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

// Check a plain property every clock, quiet while reset is asserted.
`define PST_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define PST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define PST_ASSERT(label, clk, rst_n, prop, msg)
`define PST_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/pst_pkg.sv =====
// Shared widths, sizes and codes of the peer slot table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package pst_pkg;

  localparam int SLOTS    = 16;
  localparam int SLOT_W   = 4;
  localparam int LIM_W    = 5;
  localparam int ID_W     = 32;
  localparam int KEY_W    = 32;
  localparam int SEC_W    = 63;
  localparam int NSEC_W   = 30;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(SLOTS);
  localparam logic [ID_W-1:0]  ID_FIRST    = ID_W'(1);

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_CREATE   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FREE     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FIND_ID  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_FIND_KEY = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

endpackage

`default_nettype wire

// ===== sv/pst_req_if.sv =====
// Request channel of the peer slot table: valid/ready plus the operation fields.
// Depends on pst_pkg for the field widths.
`default_nettype none

interface pst_req_if
  import pst_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SLOT_W-1:0]   slot_index;
  logic [ID_W-1:0]     peer_id;
  logic [KEY_W-1:0]    remote_key;
  logic [SEC_W-1:0]    session_seconds;
  logic [NSEC_W-1:0]   session_nanoseconds;

  modport source (
    output valid, kind, slot_index, peer_id, remote_key, session_seconds,
           session_nanoseconds,
    input  ready
  );

  modport sink (
    input  valid, kind, slot_index, peer_id, remote_key, session_seconds,
           session_nanoseconds,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/pst_rsp_if.sv =====
// Response channel of the peer slot table: valid/ready plus the result fields.
// Depends on pst_pkg for the field widths.
`default_nettype none

interface pst_rsp_if
  import pst_pkg::*;
();

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_found;
  logic [ID_W-1:0]     assigned_id;
  logic [LIM_W-1:0]    active_total;

  modport source (
    output valid, status, slot_found, assigned_id, active_total,
    input  ready
  );

  modport sink (
    input  valid, status, slot_found, assigned_id, active_total,
    output ready
  );

endinterface

`default_nettype wire

// ===== sv/peer_slot_table_with_id_allocator.sv =====
// Peer slot table with unique id allocation, one operation per request beat.
// Free, find by id, find by session key and a refused create: result registered
// from the request beat. Create: the key is stored, then ST_ALLOC skips at most
// limit + 1 candidate ids; the shared id compare bank tests one candidate a cycle.
// Throughput: one operation at a time; the next beat is taken once the result drains.
// Reset clears the active bits, sets the id counter to one and the limit to 16.
`default_nettype none
`include "peer_slot_table_with_id_allocator_macros.svh"

module peer_slot_table_with_id_allocator
  import pst_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             peer_limit_we_i,
  input  wire logic [LIM_W-1:0] peer_limit_i,
  pst_req_if.sink               req,
  pst_rsp_if.source             rsp
);

  typedef enum logic {
    ST_IDLE,
    ST_ALLOC
  } state_e;

  // Lowest set bit of a slot vector; zero when none is set.
  function automatic logic [SLOT_W-1:0] lowest_idx(input logic [SLOTS-1:0] vec);
    logic [SLOT_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (vec[i]) idx = SLOT_W'(i);
    end
    return idx;
  endfunction

  // ---------------------------------------------------------------------------
  // Control state and response register
  // ---------------------------------------------------------------------------
  state_e              state_q, state_d;
  logic [LIM_W-1:0]    peer_limit_q, peer_limit_d;
  logic [SLOTS-1:0]    active_q, active_d;
  logic [LIM_W-1:0]    cnt_q, cnt_d;
  logic [ID_W-1:0]     next_cand_q, next_cand_d;
  logic [ID_W-1:0]     cand_q, cand_d;
  logic [SLOT_W-1:0]   alloc_slot_q, alloc_slot_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] out_status_q, out_status_d;
  logic [SLOT_W-1:0]   out_slot_q, out_slot_d;
  logic [ID_W-1:0]     out_id_q, out_id_d;
  logic [LIM_W-1:0]    out_total_q, out_total_d;

  // Slot payload: written before it is ever read, so it carries no reset.
  logic [ID_W-1:0]     ident_q [SLOTS];
  logic [KEY_W-1:0]    key_q   [SLOTS];
  logic [SEC_W-1:0]    sec_q   [SLOTS];
  logic [NSEC_W-1:0]   nsec_q  [SLOTS];

  logic                key_we;
  logic                id_we;

  // ---------------------------------------------------------------------------
  // Slot compare bank
  // ---------------------------------------------------------------------------
  logic [LIM_W-1:0]    eff_lim;
  logic [SLOTS-1:0]    lim_mask;
  logic [ID_W-1:0]     cmp_id;
  logic [SLOTS-1:0]    id_hit_vec;
  logic [SLOTS-1:0]    key_hit_vec;
  logic [SLOTS-1:0]    free_vec;
  logic [SLOT_W-1:0]   id_idx, key_idx, free_idx;
  logic                cand_ok;
  logic                in_ready;
  logic                accept;

  // Clamp the limit to the built size.
  assign eff_lim = (peer_limit_q > LIMIT_RESET) ? LIMIT_RESET : peer_limit_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      lim_mask[i] = (LIM_W'(i) < eff_lim);
    end
  end

  // One id compare bank serves both the candidate test during allocation and
  // find by id; only slots that are active and below the limit take part.
  assign cmp_id = (state_q == ST_ALLOC) ? cand_q : req.peer_id;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      id_hit_vec[i]  = active_q[i] & lim_mask[i] & (ident_q[i] == cmp_id);
      key_hit_vec[i] = active_q[i] & lim_mask[i] &
                       (key_q[i] == req.remote_key) &
                       (sec_q[i] == req.session_seconds) &
                       (nsec_q[i] == req.session_nanoseconds);
    end
  end

  assign free_vec = ~active_q & lim_mask;
  assign id_idx   = lowest_idx(id_hit_vec);
  assign key_idx  = lowest_idx(key_hit_vec);
  assign free_idx = lowest_idx(free_vec);

  // A candidate passes when it is neither zero, nor all ones, nor in use.
  assign cand_ok = (cand_q != '0) && (cand_q != '1) && !(|id_hit_vec);

  // Take a request beat only in idle, with the response register empty or
  // being drained in the same cycle.
  assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
  assign accept   = req.valid && in_ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    peer_limit_d = peer_limit_we_i ? peer_limit_i : peer_limit_q;
    active_d     = active_q;
    cnt_d        = cnt_q;
    next_cand_d  = next_cand_q;
    cand_d       = cand_q;
    alloc_slot_d = alloc_slot_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_id_d     = out_id_q;
    out_total_d  = out_total_q;
    key_we       = 1'b0;
    id_we        = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req.kind)
            KIND_CREATE: begin
              if ((cnt_q < eff_lim) && (|free_vec)) begin
                // Claim the slot now; store the key, start the id search.
                key_we       = 1'b1;
                alloc_slot_d = free_idx;
                cand_d       = next_cand_q;
                state_d      = ST_ALLOC;
              end else begin
                out_valid_d  = 1'b1;
                out_status_d = STATUS_FULL;
                out_slot_d   = '0;
                out_id_d     = '0;
                out_total_d  = cnt_q;
              end
            end
            KIND_FREE: begin
              out_valid_d  = 1'b1;
              out_status_d = STATUS_OK;
              out_slot_d   = '0;
              out_id_d     = '0;
              out_total_d  = cnt_q;
              if (active_q[req.slot_index]) begin
                active_d[req.slot_index] = 1'b0;
                cnt_d       = LIM_W'(cnt_q - 1'b1);
                out_total_d = LIM_W'(cnt_q - 1'b1);
              end
            end
            KIND_FIND_ID: begin
              out_valid_d  = 1'b1;
              out_total_d  = cnt_q;
              if (|id_hit_vec) begin
                out_status_d = STATUS_OK;
                out_slot_d   = id_idx;
                out_id_d     = req.peer_id;
              end else begin
                out_status_d = STATUS_NOT_FOUND;
                out_slot_d   = '0;
                out_id_d     = '0;
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              out_total_d  = cnt_q;
              if (|key_hit_vec) begin
                out_status_d = STATUS_OK;
                out_slot_d   = key_idx;
                out_id_d     = ident_q[key_idx];
              end else begin
                out_status_d = STATUS_NOT_FOUND;
                out_slot_d   = '0;
                out_id_d     = '0;
              end
            end
          endcase
        end
      end
      ST_ALLOC: begin
        if (cand_ok) begin
          // Commit the id, activate the slot and answer.
          id_we                  = 1'b1;
          active_d[alloc_slot_q] = 1'b1;
          cnt_d                  = LIM_W'(cnt_q + 1'b1);
          next_cand_d            = ID_W'(cand_q + 1'b1);
          out_valid_d            = 1'b1;
          out_status_d           = STATUS_OK;
          out_slot_d             = alloc_slot_q;
          out_id_d               = cand_q;
          out_total_d            = LIM_W'(cnt_q + 1'b1);
          state_d                = ST_IDLE;
        end else begin
          // Advance to the next candidate; wraps at the id width.
          cand_d = ID_W'(cand_q + 1'b1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      peer_limit_q <= LIMIT_RESET;
      active_q     <= '0;
      cnt_q        <= '0;
      next_cand_q  <= ID_FIRST;
      cand_q       <= '0;
      alloc_slot_q <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= STATUS_OK;
      out_slot_q   <= '0;
      out_id_q     <= '0;
      out_total_q  <= '0;
    end else begin
      state_q      <= state_d;
      peer_limit_q <= peer_limit_d;
      active_q     <= active_d;
      cnt_q        <= cnt_d;
      next_cand_q  <= next_cand_d;
      cand_q       <= cand_d;
      alloc_slot_q <= alloc_slot_d;
      out_valid_q  <= out_valid_d;
      out_status_q <= out_status_d;
      out_slot_q   <= out_slot_d;
      out_id_q     <= out_id_d;
      out_total_q  <= out_total_d;
    end
  end

  // Slot payload storage
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_q[free_idx]  <= req.remote_key;
      sec_q[free_idx]  <= req.session_seconds;
      nsec_q[free_idx] <= req.session_nanoseconds;
    end
    if (id_we) begin
      ident_q[alloc_slot_q] <= cand_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel outputs
  // ---------------------------------------------------------------------------
  assign req.ready        = in_ready;
  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.slot_found   = out_slot_q;
  assign rsp.assigned_id  = out_id_q;
  assign rsp.active_total = out_total_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `PST_ASSERT(a_count_matches_bits, clk_i, rst_ni, $countones(active_q) == cnt_q, "active count out of step with active bits")
  `PST_ASSERT(a_next_cand_nonzero, clk_i, rst_ni, next_cand_q != '0, "id counter holds zero")
  `PST_ASSERT_IMPLY(a_alloc_out_empty, clk_i, rst_ni, state_q == ST_ALLOC, !out_valid_q, "response pending during id search")
  `PST_ASSERT_IMPLY(a_alloc_slot_free, clk_i, rst_ni, state_q == ST_ALLOC, !active_q[alloc_slot_q], "claimed slot already active")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the peer slot table with id allocator.
// Drives the request channel and checks every response beat against a built-in table predictor.
// Depends on pst_pkg, pst_req_if, pst_rsp_if and the top level.
module tb;
  import pst_pkg::*;

  localparam int NSEC_MAX    = 999_999_999;
  localparam int HOLD_CYCLES = 300;      // length of the long response hold-off
  localparam int SETTLE      = 24;       // covers the longest create id search plus margin
  localparam int CYCLE_LIMIT = 400_000;  // several times the slowest legal run
  localparam int POOL_DEPTH  = 24;

  // Remote session key: everything matched by a find-by-key.
  typedef struct packed {
    logic [KEY_W-1:0]  id;
    logic [SEC_W-1:0]  sec;
    logic [NSEC_W-1:0] nsec;
  } session_key_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SLOT_W-1:0] slot_index;
    logic [ID_W-1:0]   peer_id;
    session_key_t      key;
  } table_op_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_found;
    logic [ID_W-1:0]     assigned_id;
    logic [LIM_W-1:0]    active_total;
  } table_result_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             limit_we;
  logic [LIM_W-1:0] limit_wdata;

  pst_req_if req_if ();
  pst_rsp_if rsp_if ();

  peer_slot_table_with_id_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .peer_limit_we_i (limit_we),
    .peer_limit_i    (limit_wdata),
    .req             (req_if),
    .rsp             (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // Mirror of the table: active bits, ids, session keys, id counter, limit.
  bit               tbl_active [SLOTS];
  logic [ID_W-1:0]  tbl_id     [SLOTS];
  session_key_t     tbl_key    [SLOTS];
  logic [ID_W-1:0]  tbl_next_id;
  logic [LIM_W-1:0] tbl_limit;
  int               tbl_count;

  table_result_t pending_results [$];
  session_key_t  key_pool [$];        // recently used keys, reused for hits and duplicates
  int            fail_count  = 0;
  int            cycle_count = 0;
  logic          idle_on      = 1'b1;
  logic          hold_request = 1'b0;
  int            hold_left    = 0;

  // Apply one operation to the mirror and return the response it must produce.
  function automatic table_result_t apply_table_op(table_op_t op);
    table_result_t   r;
    int              lim;
    int              free_slot;
    logic [ID_W-1:0] cand;
    bit              taken;
    r        = '0;
    r.status = STATUS_OK;
    lim      = (int'(tbl_limit) > SLOTS) ? SLOTS : int'(tbl_limit);
    case (op.kind)
      KIND_CREATE: begin
        // Take the lowest idle slot below the limit, if the count allows one.
        free_slot = lim;
        if (tbl_count < lim) begin
          for (int i = lim - 1; i >= 0; i--) if (!tbl_active[i]) free_slot = i;
        end
        if (free_slot >= lim) begin
          r.status = STATUS_FULL;
        end else begin
          // Skip zero, all-ones and ids held by a slot below the limit.
          cand = tbl_next_id;
          do begin
            taken = (cand == '0) || (cand == '1);
            for (int i = 0; i < lim; i++) if (tbl_active[i] && tbl_id[i] == cand) taken = 1'b1;
            if (taken) cand++;
          end while (taken);
          tbl_next_id          = cand + 1'b1;
          tbl_active[free_slot] = 1'b1;
          tbl_id[free_slot]     = cand;
          tbl_key[free_slot]    = op.key;
          tbl_count++;
          r.slot_found  = SLOT_W'(free_slot);
          r.assigned_id = cand;
        end
      end
      KIND_FREE: begin
        // Freeing an idle slot leaves everything as it is.
        if (tbl_active[op.slot_index]) begin
          tbl_active[op.slot_index] = 1'b0;
          tbl_count--;
        end
      end
      default: begin
        // Both finds report the lowest matching active slot below the limit.
        r.status = STATUS_NOT_FOUND;
        for (int i = lim - 1; i >= 0; i--) begin
          if (tbl_active[i] && ((op.kind == KIND_FIND_ID) ? (tbl_id[i] == op.peer_id)
                                                          : (tbl_key[i] == op.key))) begin
            r.status      = STATUS_OK;
            r.slot_found  = SLOT_W'(i);
            r.assigned_id = tbl_id[i];
          end
        end
      end
    endcase
    r.active_total = LIM_W'(tbl_count);
    return r;
  endfunction

  function automatic session_key_t fresh_key();
    session_key_t k;
    k.id   = $urandom;
    k.sec  = SEC_W'({$urandom, $urandom});
    k.nsec = NSEC_W'($urandom_range(NSEC_MAX));
    return k;
  endfunction

  function automatic table_op_t make_op(logic [KIND_W-1:0] kind, logic [SLOT_W-1:0] slot,
                                        logic [ID_W-1:0] pid, session_key_t key);
    table_op_t op;
    op.kind       = kind;
    op.slot_index = slot;
    op.peer_id    = pid;
    op.key        = key;
    return op;
  endfunction

  // Random operation with random content in the unused fields too. Most frees hit live
  // slots, most finds reuse ids and keys that were handed out, some are near misses.
  function automatic table_op_t random_op(int create_pct);
    table_op_t op;
    int        pick;
    int        live [$];
    op.slot_index = SLOT_W'($urandom);
    op.peer_id    = $urandom;
    op.key        = fresh_key();
    pick          = $urandom_range(99);
    if (pick < create_pct) begin
      op.kind = KIND_CREATE;
      if (key_pool.size() != 0 && $urandom_range(99) < 40)
        op.key = key_pool[$urandom_range(key_pool.size() - 1)];
      key_pool.push_back(op.key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end else begin
      pick = $urandom_range(99);
      case ($urandom_range(2))
        0: begin
          op.kind = KIND_FREE;
          for (int i = 0; i < SLOTS; i++) if (tbl_active[i]) live.push_back(i);
          if (live.size() != 0 && pick < 75)
            op.slot_index = SLOT_W'(live[$urandom_range(live.size() - 1)]);
        end
        1: begin
          op.kind = KIND_FIND_ID;
          if (pick < 55)      op.peer_id = tbl_id[$urandom_range(SLOTS - 1)];
          else if (pick < 70) op.peer_id = $urandom_range(40);
          else if (pick < 75) op.peer_id = '1;
        end
        default: begin
          op.kind = KIND_FIND_KEY;
          if (key_pool.size() != 0 && pick < 75) begin
            op.key = key_pool[$urandom_range(key_pool.size() - 1)];
            if (pick >= 50) begin
              case ($urandom_range(2))
                0:       op.key.id  ^= KEY_W'(1) << $urandom_range(KEY_W - 1);
                1:       op.key.sec ^= SEC_W'(1) << $urandom_range(SEC_W - 1);
                default: op.key.nsec ^= NSEC_W'(1);
              endcase
            end
          end
        end
      endcase
    end
    return op;
  endfunction

  // Offer one request beat, idling first at random; predict it once it is taken.
  // Valid stays high after the beat so back-to-back beats need no extra edge.
  task automatic send_op(input table_op_t op);
    while (idle_on && $urandom_range(99) < 27) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid               <= 1'b1;
    req_if.kind                <= op.kind;
    req_if.slot_index          <= op.slot_index;
    req_if.peer_id             <= op.peer_id;
    req_if.remote_key          <= op.key.id;
    req_if.session_seconds     <= op.key.sec;
    req_if.session_nanoseconds <= op.key.nsec;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(apply_table_op(op));
  endtask

  task automatic run_random_ops(input int count, input int create_pct);
    for (int n = 0; n < count; n++) send_op(random_op(create_pct));
  endtask

  // Drop valid, wait for every response, then let a create in flight settle.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write the limit only while the table is idle; the mirror follows the write edge.
  task automatic set_limit(input logic [LIM_W-1:0] value);
    wait_idle();
    limit_we    <= 1'b1;
    limit_wdata <= value;
    @(posedge clk_i);
    limit_we    <= 1'b0;
    tbl_limit    = value;
  endtask

  // Empty table, creates with extreme keys, duplicate keys, near misses, free and reuse.
  task automatic test_directed_ops();
    session_key_t k_zero;
    session_key_t k_top;
    session_key_t k_miss;
    k_zero      = '0;
    k_top.id    = '1;
    k_top.sec   = '1;
    k_top.nsec  = NSEC_W'(NSEC_MAX);
    k_miss      = k_zero;
    k_miss.nsec = NSEC_W'(1);
    // Nothing to find yet; freeing an idle slot is a no-op.
    send_op(make_op(KIND_FIND_ID,  0,  '0, k_zero));
    send_op(make_op(KIND_FIND_ID,  0,  '1, k_top));
    send_op(make_op(KIND_FIND_KEY, 0,  '0, k_zero));
    send_op(make_op(KIND_FREE,     '1, '0, k_zero));
    // Slots 0 and 2 share a key; slot 1 holds the top key (all-ones id and seconds).
    send_op(make_op(KIND_CREATE, 0,  '0, k_zero));
    send_op(make_op(KIND_CREATE, '1, '1, k_top));
    send_op(make_op(KIND_CREATE, 0,  '0, k_zero));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_zero));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_top));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_miss));
    send_op(make_op(KIND_FIND_ID,  0, ID_W'(2), k_zero));
    // Free the lowest copy: the key now resolves to slot 2; a second free changes nothing.
    send_op(make_op(KIND_FREE,     0, '0, k_zero));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_zero));
    send_op(make_op(KIND_FREE,     0, '0, k_zero));
    // The freed slot is reused with a fresh id.
    send_op(make_op(KIND_CREATE,  0, '0, k_miss));
    send_op(make_op(KIND_FIND_ID, 0, ID_W'(4), k_zero));
  endtask

  // Lower the limit under live slots: creates refuse and slots above it are not seen.
  task automatic test_limit_extremes();
    session_key_t k_top;
    k_top.id   = '1;
    k_top.sec  = '1;
    k_top.nsec = NSEC_W'(NSEC_MAX);
    set_limit(LIM_W'(2));
    send_op(make_op(KIND_CREATE,   0, '0, k_top));
    send_op(make_op(KIND_FIND_ID,  0, ID_W'(3), k_top));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_top));
    set_limit(LIM_W'(1));
    send_op(make_op(KIND_CREATE,   0, '0, k_top));
    send_op(make_op(KIND_FIND_KEY, 0, '0, k_top));
    send_op(make_op(KIND_FREE,     '1, '0, k_top));
    // Slots above the limit may still be freed.
    send_op(make_op(KIND_FREE,     SLOT_W'(2), '0, k_top));
  endtask

  // Create-heavy traffic at the full size, so the table fills and refuses.
  task automatic test_fill_to_full();
    set_limit(LIM_W'(SLOTS));
    run_random_ops(120, 60);
  endtask

  // Churn at the smallest and largest limits and a few random ones.
  task automatic test_limit_sweep();
    for (int i = 0; i < 6; i++) begin
      set_limit((i == 0) ? LIM_W'(1) : (i == 1) ? LIM_W'(SLOTS)
                                                : LIM_W'($urandom_range(SLOTS, 1)));
      run_random_ops(50, 45);
    end
  endtask

  // Both sides at full rate for a long stretch.
  task automatic test_steady_no_idle();
    set_limit(LIM_W'(SLOTS));
    idle_on <= 1'b0;
    run_random_ops(100, 40);
    idle_on <= 1'b1;
  endtask

  // Hold off the response side while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    wait_idle();
    idle_on      <= 1'b0;
    hold_request <= 1'b1;
    run_random_ops(40, 40);
    idle_on      <= 1'b1;
  endtask

  // Response ready: random idling, or a long hold-off counted here when asked for.
  always @(posedge clk_i) begin
    if (hold_request) begin
      hold_request <= 1'b0;
      hold_left    <= HOLD_CYCLES - 1;
      rsp_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= !(idle_on && $urandom_range(99) < 27);
    end
  end

  // Compare each response beat with the oldest prediction, field by field.
  always @(posedge clk_i) begin : result_check
    table_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("response beat with no request outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          fail_count++;
        end
        if (rsp_if.slot_found !== want.slot_found) begin
          $error("slot_found: expected %0d, got %0d", want.slot_found, rsp_if.slot_found);
          fail_count++;
        end
        if (rsp_if.assigned_id !== want.assigned_id) begin
          $error("assigned_id: expected %0h, got %0h", want.assigned_id, rsp_if.assigned_id);
          fail_count++;
        end
        if (rsp_if.active_total !== want.active_total) begin
          $error("active_total: expected %0d, got %0d", want.active_total,
                 rsp_if.active_total);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles", CYCLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    // Every input known from time zero.
    rst_ni                     = 1'b0;
    limit_we                   = 1'b0;
    limit_wdata                = '0;
    req_if.valid               = 1'b0;
    req_if.kind                = KIND_CREATE;
    req_if.slot_index          = '0;
    req_if.peer_id             = '0;
    req_if.remote_key          = '0;
    req_if.session_seconds     = '0;
    req_if.session_nanoseconds = '0;
    rsp_if.ready               = 1'b0;
    // Mirror the reset state.
    for (int i = 0; i < SLOTS; i++) begin
      tbl_active[i] = 1'b0;
      tbl_id[i]     = '0;
      tbl_key[i]    = '0;
    end
    tbl_next_id = ID_FIRST;
    tbl_limit   = LIMIT_RESET;
    tbl_count   = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_limit_extremes();
    test_fill_to_full();
    test_limit_sweep();
    test_steady_no_idle();
    test_output_backpressure();
    wait_idle();

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
